FILE: sv/ffha_pkg.sv
package ffha_pkg;

  localparam int HEAP_MAX_BYTES_DEF = 65536;
  localparam int HEADER_BYTES_DEF   = 12;
  localparam int SPLIT_SLACK_DEF    = 16;

  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 17;
  localparam int COUNT_W    = 17;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_BYTES = 1'b1
  } cfg_index_t;

endpackage

FILE: sv/first_fit_heap_allocator.sv
// First-fit heap allocator with block splitting and coalescing.
//
// Input channel (in_valid/in_ready): one transaction is an allocate (cmd 0,
// request_bytes) or a free (cmd 1, release_address). Output channel
// (out_valid/out_ready): exactly one result transaction per input, in order,
// carrying status, granted_address and the used and available byte counts.
// Configuration writes (cfg_we, cfg_addr, cfg_data) set heap_base or heap_bytes
// and restart the heap; users issue them only while the block idles (no check).
//
// The block headers live in one synchronous RAM, one entry per 4-byte
// granule, with a registered read. Every header visit has two steps
// (address, then evaluate). An allocate visits headers in order until one
// fits, then, when the chosen block is split, writes the tail header in a
// further step. A free walks to its block and then makes one full
// coalescing pass over the chain. The walk over the header RAM sets the
// rate; one item is in work at a time.
//
// After reset, and after any configuration write, the block writes the single
// free header at granule zero, if a header fits, before it takes input.
// A finished result waits in the output register while the receiver stalls;
// the next input transaction may be accepted meanwhile, but its own result
// holds until the output register is free again.
module first_fit_heap_allocator #(
  parameter int HEAP_MAX_BYTES = ffha_pkg::HEAP_MAX_BYTES_DEF,
  parameter int HEADER_BYTES   = ffha_pkg::HEADER_BYTES_DEF,
  parameter int SPLIT_SLACK    = ffha_pkg::SPLIT_SLACK_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_addr,
  input  logic [ffha_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [ffha_pkg::REQ_W-1:0]      request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]     release_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [ffha_pkg::ADDR_W-1:0]     granted_address,
  output logic [ffha_pkg::COUNT_W-1:0]    bytes_in_use,
  output logic [ffha_pkg::COUNT_W-1:0]    bytes_available
);
  import ffha_pkg::*;

  // Offsets and sizes fit OW bits; XW leaves headroom for sums and the
  // rounded request.
  localparam int OW    = $clog2(HEAP_MAX_BYTES + 1);
  localparam int XW    = ((OW > REQ_W) ? OW : REQ_W) + 2;
  localparam int DEPTH = HEAP_MAX_BYTES / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [XW-1:0] HDR_X   = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] SLACK_X = XW'(SPLIT_SLACK);
  localparam logic [XW-1:0] MAX_X   = XW'(HEAP_MAX_BYTES);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_EV, S_A_SPLIT,
    S_F_RD, S_F_EV, S_M_RD, S_M_EV, S_FIN
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] heap_base;
  logic [REQ_W-1:0]  heap_bytes;
  logic [OW-1:0]     in_use;
  logic [OW-1:0]     off;
  logic [XW-1:0]     need;
  logic [OW-1:0]     rel;
  logic [OW-1:0]     tail_off;
  logic [OW-1:0]     tail_size;
  logic [OW-1:0]     run_off;
  logic [OW-1:0]     run_size;
  logic              run_free;
  logic              run_dirty;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;

  // Header RAM: bit OW is the used flag, the rest the payload size.
  logic [OW:0] hdr_mem [DEPTH];
  logic [OW:0] mem_rdata;
  logic [OW:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic          mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= hdr_mem[mem_raddr];
  end

  // Effective heap size: clipped to the maximum and rounded down to 4 bytes.
  logic [XW-1:0] hb_x, eff_x;
  logic          heap_empty;
  assign hb_x       = XW'(heap_bytes);
  assign eff_x      = ((hb_x > MAX_X) ? MAX_X : hb_x) & ~XW'(3);
  assign heap_empty = eff_x < HDR_X;

  logic          rd_used;
  logic [XW-1:0] rd_size_x, off_x, pay_x, next_off_x, rel_x, in_use_x;
  logic          walk_end, fit, split, hit, merge;
  logic [XW-1:0] rel_full_x, req_round_x;
  logic [ADDR_W-1:0] rel_full;

  assign rd_used     = mem_rdata[OW];
  assign rd_size_x   = XW'(mem_rdata[OW-1:0]);
  assign off_x       = XW'(off);
  assign pay_x       = off_x + HDR_X;
  assign next_off_x  = pay_x + rd_size_x;
  assign rel_x       = XW'(rel);
  assign in_use_x    = XW'(in_use);
  assign walk_end    = heap_empty || (off_x >= eff_x);
  assign fit         = !rd_used && (rd_size_x >= need);
  assign split       = rd_size_x > (need + HDR_X + SLACK_X);
  assign hit         = pay_x == rel_x;
  assign merge       = !rd_used && run_free;
  assign rel_full    = release_address - heap_base;
  assign rel_full_x  = (rel_full >= ADDR_W'(eff_x)) ? eff_x : XW'(rel_full);
  assign req_round_x = (XW'(request_bytes) + XW'(3)) & ~XW'(3);

  always_comb begin
    mem_raddr = off[AW+1:2];
    mem_we    = 1'b0;
    mem_waddr = off[AW+1:2];
    mem_wdata = {1'b0, rd_size_x[OW-1:0]};
    unique case (state)
      S_INIT: begin
        mem_we    = !heap_empty;
        mem_waddr = '0;
        mem_wdata = {1'b0, OW'(eff_x - HDR_X)};
      end
      S_A_EV: begin
        mem_we    = fit;
        mem_wdata = {1'b1, split ? need[OW-1:0] : rd_size_x[OW-1:0]};
      end
      S_A_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = tail_off[AW+1:2];
        mem_wdata = {1'b0, tail_size};
      end
      S_F_EV: begin
        mem_we = hit && rd_used;
      end
      S_M_RD: begin
        mem_we    = walk_end && run_dirty;
        mem_waddr = run_off[AW+1:2];
        mem_wdata = {1'b0, run_size};
      end
      S_M_EV: begin
        mem_we    = !merge && run_dirty;
        mem_waddr = run_off[AW+1:2];
        mem_wdata = {1'b0, run_size};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      heap_base  <= '0;
      heap_bytes <= REQ_W'(65536);
      in_use     <= '0;
      out_valid  <= 1'b0;
      run_free   <= 1'b0;
      run_dirty  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_HEAP_BASE) begin
          heap_base <= cfg_data;
        end else begin
          heap_bytes <= cfg_data[REQ_W-1:0];
        end
        state <= S_INIT;
      end else begin
        unique case (state)
          S_INIT: begin
            in_use <= '0;
            state  <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              off      <= '0;
              res_addr <= '0;
              need     <= req_round_x;
              rel      <= rel_full_x[OW-1:0];
              if (cmd == CMD_ALLOC) begin
                state <= S_A_RD;
              end else if (release_address == '0 || XW'(rel_full) != rel_full_x
                           || rel_full_x >= eff_x) begin
                res_status <= ST_IGNORED;
                state      <= S_FIN;
              end else begin
                state <= S_F_RD;
              end
            end
          end
          S_A_RD: begin
            if (walk_end) begin
              res_status <= ST_NO_FIT;
              state      <= S_FIN;
            end else begin
              state <= S_A_EV;
            end
          end
          S_A_EV: begin
            if (fit) begin
              res_status <= ST_ALLOCATED;
              res_addr   <= heap_base + ADDR_W'(pay_x);
              if (split) begin
                in_use    <= OW'(in_use_x + need + HDR_X);
                tail_off  <= OW'(pay_x + need);
                tail_size <= OW'(rd_size_x - need - HDR_X);
                state     <= S_A_SPLIT;
              end else begin
                in_use <= OW'(in_use_x + rd_size_x + HDR_X);
                state  <= S_FIN;
              end
            end else begin
              off   <= OW'(next_off_x);
              state <= S_A_RD;
            end
          end
          S_A_SPLIT: begin
            state <= S_FIN;
          end
          S_F_RD: begin
            if (walk_end || pay_x > rel_x) begin
              res_status <= ST_IGNORED;
              state      <= S_FIN;
            end else begin
              state <= S_F_EV;
            end
          end
          S_F_EV: begin
            if (hit) begin
              if (!rd_used) begin
                res_status <= ST_IGNORED;
                state      <= S_FIN;
              end else begin
                // Block released; now coalesce the whole chain from the start.
                res_status <= ST_FREED;
                in_use     <= OW'(in_use_x - rd_size_x - HDR_X);
                off        <= '0;
                run_free   <= 1'b0;
                run_dirty  <= 1'b0;
                state      <= S_M_RD;
              end
            end else begin
              off   <= OW'(next_off_x);
              state <= S_F_RD;
            end
          end
          S_M_RD: begin
            state <= walk_end ? S_FIN : S_M_EV;
          end
          S_M_EV: begin
            if (merge) begin
              run_size  <= OW'(XW'(run_size) + HDR_X + rd_size_x);
              run_dirty <= 1'b1;
            end else begin
              run_off   <= off;
              run_size  <= rd_size_x[OW-1:0];
              run_free  <= !rd_used;
              run_dirty <= 1'b0;
            end
            off   <= OW'(next_off_x);
            state <= S_M_RD;
          end
          S_FIN: begin
            if (!out_valid || out_ready) begin
              out_valid       <= 1'b1;
              status          <= res_status;
              granted_address <= res_addr;
              bytes_in_use    <= COUNT_W'(in_use_x);
              bytes_available <= COUNT_W'(eff_x - in_use_x);
              state           <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

FILE: sv/ffha_checker.sv
module ffha_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [ffha_pkg::ADDR_W-1:0] granted_address
);
  import ffha_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(granted_address))
    else $error("result changed while stalled");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ALLOCATED |-> granted_address == '0)
    else $error("address given without allocation");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in work");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .granted_address (granted_address)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import ffha_pkg::*;

  localparam int HEAP_MAX = HEAP_MAX_BYTES_DEF;
  localparam int HDR      = HEADER_BYTES_DEF;
  localparam int SLACK    = SPLIT_SLACK_DEF;
  localparam int MAXBLK   = HEAP_MAX / 4 + 1;

  // One transaction on the request channel.
  typedef struct packed {
    cmd_t        op;
    logic [16:0] nbytes;
    logic [31:0] addr;
  } heap_req_t;

  // One transaction on the result channel.
  typedef struct packed {
    status_t     st;
    logic [31:0] addr;
    logic [16:0] used;
    logic [16:0] avail;
  } heap_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [16:0] request_bytes = '0;
  logic [31:0] release_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] granted_address;
  logic [16:0] bytes_in_use;
  logic [16:0] bytes_available;

  first_fit_heap_allocator u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .request_bytes(request_bytes), .release_address(release_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .granted_address(granted_address),
    .bytes_in_use(bytes_in_use), .bytes_available(bytes_available)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the heap: an ordered list of blocks, each with a used flag and
  // a payload size, plus the running count of bytes held by used blocks.
  logic [31:0] shadow_base;
  logic [31:0] shadow_bytes;
  int unsigned blk_size [MAXBLK];
  bit          blk_used [MAXBLK];
  int unsigned blk_count;
  int unsigned held_bytes;

  // Addresses handed out and not yet freed, used to build realistic frees.
  logic [31:0] live_grants[$];

  heap_req_t  pending_reqs[$];
  heap_resp_t expected_resps[$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_grants = 0;
  int n_nofit = 0;
  int n_freed = 0;
  int n_ignored = 0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_receiver = 1'b0;
  bit hold_start = 1'b0;

  function automatic int unsigned usable_bytes();
    int unsigned h;
    h = shadow_bytes;
    if (h > HEAP_MAX) h = HEAP_MAX;
    return h & ~32'd3;
  endfunction

  function automatic void restart_heap();
    int unsigned h;
    h = usable_bytes();
    held_bytes = 0;
    if (h < HDR) begin
      blk_count = 0;
    end else begin
      blk_count = 1;
      blk_size[0] = h - HDR;
      blk_used[0] = 1'b0;
    end
  endfunction

  function automatic void coalesce();
    int unsigned i;
    int unsigned j;
    i = 0;
    while (i + 1 < blk_count) begin
      if (!blk_used[i] && !blk_used[i+1]) begin
        blk_size[i] += HDR + blk_size[i+1];
        for (j = i + 1; j + 1 < blk_count; j++) begin
          blk_size[j] = blk_size[j+1];
          blk_used[j] = blk_used[j+1];
        end
        blk_count--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic status_t take_first_fit(int unsigned req, output logic [31:0] addr);
    int unsigned need;
    int unsigned off;
    int unsigned j;
    need = (req + 3) & ~32'd3;
    off = 0;
    addr = '0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!blk_used[i] && blk_size[i] >= need) begin
        if (blk_size[i] > need + HDR + SLACK && blk_count < MAXBLK) begin
          for (j = blk_count; j > i + 1; j--) begin
            blk_size[j] = blk_size[j-1];
            blk_used[j] = blk_used[j-1];
          end
          blk_size[i+1] = blk_size[i] - need - HDR;
          blk_used[i+1] = 1'b0;
          blk_count++;
          blk_size[i] = need;
        end
        blk_used[i] = 1'b1;
        held_bytes += blk_size[i] + HDR;
        addr = shadow_base + off + HDR;
        return ST_ALLOCATED;
      end
      off += HDR + blk_size[i];
    end
    return ST_NO_FIT;
  endfunction

  function automatic status_t release_block(logic [31:0] addr);
    logic [31:0] rel;
    int unsigned off;
    int unsigned pay;
    if (addr == 0) return ST_IGNORED;
    rel = addr - shadow_base;
    if (rel >= usable_bytes()) return ST_IGNORED;
    off = 0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      pay = off + HDR;
      if (pay == rel) begin
        if (!blk_used[i]) return ST_IGNORED;
        blk_used[i] = 1'b0;
        held_bytes -= blk_size[i] + HDR;
        coalesce();
        return ST_FREED;
      end
      if (pay > rel) return ST_IGNORED;
      off = pay + blk_size[i];
    end
    return ST_IGNORED;
  endfunction

  // Works out the result of one accepted request and updates the shadow.
  function automatic heap_resp_t heap_outcome(heap_req_t r);
    heap_resp_t res;
    logic [31:0] a;
    a = '0;
    if (r.op == CMD_ALLOC) res.st = take_first_fit(r.nbytes, a);
    else res.st = release_block(r.addr);
    res.addr  = a;
    res.used  = held_bytes[16:0];
    res.avail = 17'(usable_bytes() - held_bytes);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: result %0d %s mismatch: got 0x%0h, expected 0x%0h",
             n_checked, what, got, want);
    errors++;
  endtask

  // Driver: offers the oldest pending request, keeping valid and payload
  // steady until the transaction completes. Gaps are inserted only when no
  // request is on the bus.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        void'(pending_reqs.pop_front());
        n_sent++;
      end
      if ((!in_valid || in_ready)) begin
        if (in_valid && in_ready) begin
          // The payload for the next request is chosen below.
        end
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid        <= 1'b1;
          cmd             <= pending_reqs[0].op;
          request_bytes   <= pending_reqs[0].nbytes;
          release_address <= pending_reqs[0].addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The prediction runs when a request is accepted, so the shadow follows
  // the block's own order of work.
  always @(posedge clk) begin
    heap_req_t r;
    heap_resp_t e;
    if (!rst && in_valid && in_ready) begin
      r.op = cmd_t'(cmd);
      r.nbytes = request_bytes;
      r.addr = release_address;
      e = heap_outcome(r);
      expected_resps.push_back(e);
      if (e.st == ST_ALLOCATED) live_grants.push_back(e.addr);
      if (e.st == ST_FREED) begin
        foreach (live_grants[k]) begin
          if (live_grants[k] == r.addr) begin
            live_grants.delete(k);
            break;
          end
        end
      end
    end
  end

  // Monitor: compares each completed result with the oldest expectation.
  always @(posedge clk) begin
    heap_resp_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        $display("tb: result with no request outstanding");
        errors++;
      end else begin
        e = expected_resps.pop_front();
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (granted_address !== e.addr) report_mismatch("address", granted_address, e.addr);
        if (bytes_in_use !== e.used) report_mismatch("in use", bytes_in_use, e.used);
        if (bytes_available !== e.avail)
          report_mismatch("available", bytes_available, e.avail);
        case (e.st)
          ST_ALLOCATED: n_grants++;
          ST_NO_FIT:    n_nofit++;
          ST_FREED:     n_freed++;
          default:      n_ignored++;
        endcase
      end
      n_checked++;
    end
  end

  // Receiver readiness, redrawn each cycle unless a long hold is on.
  always @(posedge clk) begin
    if (rst || hold_receiver) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Long receiver hold, counted in cycles here once the stimulus asks for it.
  initial begin
    wait (hold_start);
    hold_receiver = 1'b1;
    repeat (400) @(posedge clk);
    hold_receiver = 1'b0;
  end

  task automatic queue_alloc(int unsigned n);
    heap_req_t r;
    r.op = CMD_ALLOC;
    r.nbytes = n[16:0];
    r.addr = '0;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_free(logic [31:0] a);
    heap_req_t r;
    r.op = CMD_FREE;
    r.nbytes = 17'($urandom);
    r.addr = a;
    pending_reqs.push_back(r);
  endtask

  // Waits until every queued request has completed and its result checked,
  // then lets the block settle before any register write.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEAP_BASE) shadow_base = val;
    else shadow_bytes = val[16:0];
    restart_heap();
    live_grants.delete();
    repeat (4) @(posedge clk);
  endtask

  // Mostly allocate and free the live grants, with some noise frees:
  // odd addresses, addresses outside the heap, nulls, double frees.
  task automatic random_burst(int n, int unsigned max_req);
    logic [31:0] a;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        if ($urandom_range(19) == 0) queue_alloc($urandom_range(65536));
        else queue_alloc($urandom_range(max_req));
      end else if (pick < 85 && live_grants.size() > 0) begin
        a = live_grants[$urandom_range(live_grants.size() - 1)];
        queue_free(a);
      end else begin
        case ($urandom_range(4))
          0: a = '0;
          1: a = $urandom;
          2: a = shadow_base + $urandom_range(usable_bytes() + 64);
          3: a = shadow_base - 4;
          default: a = shadow_base + HDR;
        endcase
        queue_free(a);
      end
      // Requests are consumed as they complete, so the free choices see a
      // current list of live grants.
      while (pending_reqs.size() > 2) @(posedge clk);
    end
  endtask

  initial begin
    shadow_base = '0;
    shadow_bytes = 65536;
    restart_heap();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    // Directed: extremes on the reset heap.
    queue_alloc(0);
    queue_alloc(1);
    queue_alloc(65536);
    queue_alloc(100);
    queue_alloc(40);
    queue_free(32'd0);
    queue_free(32'hFFFF_FFFF);
    queue_free(32'd13);
    queue_free(32'd12);
    queue_free(32'd12);
    queue_free(32'd28);
    queue_alloc(5);
    queue_alloc(65536 - 200);
    queue_alloc(131071);
    drain();

    // Tiny heaps: smaller than a header, and the minimum.
    write_reg(CFG_HEAP_BYTES, 32'd8);
    queue_alloc(0);
    queue_free(32'd12);
    drain();
    write_reg(CFG_HEAP_BYTES, 32'd16);
    queue_alloc(4);
    queue_alloc(0);
    queue_free(32'd12);
    drain();

    // Base near the top so a grant wraps through address zero.
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF4);
    write_reg(CFG_HEAP_BYTES, 32'd131071);
    queue_alloc(8);
    queue_free(32'd0);
    queue_alloc(8);
    drain();

    // Random phases over several settings and idling patterns.
    write_reg(CFG_HEAP_BASE, $urandom);
    write_reg(CFG_HEAP_BYTES, 32'd1024);
    random_burst(150, 200);
    drain();

    sender_idle_pct = 87;
    write_reg(CFG_HEAP_BASE, 32'h0000_1000);
    write_reg(CFG_HEAP_BYTES, 32'd2050);
    random_burst(150, 300);
    drain();

    sender_idle_pct = 0;
    receiver_stall_pct = 87;
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFC);
    random_burst(150, 64);
    drain();

    sender_idle_pct = 21;
    receiver_stall_pct = 21;
    write_reg(CFG_HEAP_BYTES, 32'd512);
    random_burst(150, 100);

    // Long receiver hold while requests keep coming, so input backs up.
    for (int i = 0; i < 6; i++) queue_alloc($urandom_range(40));
    hold_start = 1'b1;
    wait (hold_receiver);
    wait (!hold_receiver);
    drain();

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_reg(CFG_HEAP_BASE, 32'd0);
    write_reg(CFG_HEAP_BYTES, 32'd4096);
    random_burst(180, 600);
    drain();

    $display("tb: %0d requests checked: %0d grants, %0d no-fit, %0d freed, %0d ignored",
             n_checked, n_grants, n_nofit, n_freed, n_ignored);
    $display("tb: covered tiny, wrapping and mid-size heaps under four idling patterns");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // A heap of 4 KB holds at most about 340 headers, and a free walks the
  // chain twice; 50 ms covers the whole run many times over.
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ffha_pkg.sv
sv/first_fit_heap_allocator.sv
sv/ffha_checker.sv
test/tb.sv
